// ===== rtl/can_dr_pkg.sv =====
package can_dr_pkg;

    localparam int SLOTS     = 4;
    localparam int MAX_BYTES = 72;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int POS_W     = $clog2(MAX_BYTES + 1);
    localparam int DEPTH     = SLOTS * MAX_BYTES;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int KEY_W     = 24;

    localparam logic [2:0] TYPE_SINGLE = 3'd2;
    localparam logic [2:0] TYPE_FIRST  = 3'd3;
    localparam logic [2:0] TYPE_MIDDLE = 3'd4;
    localparam logic [2:0] TYPE_FINAL  = 3'd5;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_ORDER  = 2'd1;
    localparam logic [1:0] ERR_LONG   = 2'd2;
    localparam logic [1:0] ERR_NOSLOT = 2'd3;

    localparam logic KIND_CHUNK  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WRITE,
        S_RADDR,
        S_RDATA,
        S_PUSH
    } state_t;

endpackage

// ===== rtl/can_dr_ram.sv =====
module can_dr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 288
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/can_datagram_reassembler.sv =====
// can datagram reassembler
// input stream: one extended can frame per word; s_tdata carries the
// identifier, the length code and the payload, s_tuser the local-destination
// flag. frames of other types or for remote nodes are dropped.
// output stream: datagram chunks of up to eight bytes, or one rejection notice
// per protocol error; m_tlast marks the final chunk and every rejection.
// timing: a frame is accepted only while the control is idle. a first or
// middle frame passes the decide and write states, the latter writing one byte
// to the ram per cycle; a single frame or rejection goes from decide to push.
// a final frame then reads the gathered bytes through an address and a data
// state per byte, one byte at a time with no overlap, and pushes each chunk.
// the result sits in an output register: the next frame is accepted while it
// waits, and a stalled receiver only holds the control in its push state.
// reset closes all slots and empties the output register; the byte ram needs
// no clearing since it is read only below a slot's gathered length.
module can_datagram_reassembler (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // frame_id, byte_count, frame_data, zero pad
    input  logic [0:0]   s_tuser,  // dest_local
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // src_alias, dst_alias, chunk_data, chunk_bytes, zero pad
    output logic [2:0]   m_tuser,  // kind, error_kind
    output logic         m_tlast
);

    localparam int SLOTS  = can_dr_pkg::SLOTS;
    localparam int SLOT_W = can_dr_pkg::SLOT_W;
    localparam int POS_W  = can_dr_pkg::POS_W;
    localparam int ADDR_W = can_dr_pkg::ADDR_W;
    localparam int KEY_W  = can_dr_pkg::KEY_W;

    can_dr_pkg::state_t state_reg, state_next;

    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [KEY_W-1:0] key_tab_reg [SLOTS];
    logic [KEY_W-1:0] key_tab_next [SLOTS];
    logic [POS_W-1:0] len_tab_reg [SLOTS];
    logic [POS_W-1:0] len_tab_next [SLOTS];

    logic [2:0]        type_reg, type_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [3:0]        n_reg, n_next;
    logic [63:0]       data_reg, data_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  len_reg, len_next;
    logic [POS_W-1:0]  off_reg, off_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [63:0]       buf_reg, buf_next;
    logic              res_kind_reg, res_kind_next;
    logic [1:0]        res_err_reg, res_err_next;
    logic              res_last_reg, res_last_next;

    logic              out_valid_reg, out_valid_next;
    logic [95:0]       out_data_reg, out_data_next;
    logic [2:0]        out_user_reg, out_user_next;
    logic              out_last_reg, out_last_next;

    logic [28:0] in_id;
    logic [3:0]  in_n;
    logic [63:0] in_data;
    logic [63:0] in_masked;
    logic        in_acc;
    logic        in_keep;

    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [POS_W:0]    sum_len;
    logic              too_long;
    logic              write_done;
    logic              push_ok;
    logic [POS_W-1:0]  off_inc;
    logic [3:0]        cnt_inc;
    logic              chunk_end;

    logic              ram_we;
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    assign in_id   = s_tdata[28:0];
    assign in_n    = (s_tdata[32:29] > 4'd8) ? 4'd8 : s_tdata[32:29];
    assign in_data = s_tdata[96:33];
    assign in_acc  = s_tvalid && s_tready;
    assign in_keep = s_tuser[0] && (in_id[26:24] inside
                     {[can_dr_pkg::TYPE_SINGLE:can_dr_pkg::TYPE_FINAL]});

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            in_masked[i*8 +: 8] = (4'(i) < in_n) ? in_data[i*8 +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        hit        = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (key_tab_reg[i] == key_reg))
            begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign sum_len    = (POS_W+1)'(len_tab_reg[hit_idx]) + (POS_W+1)'(n_reg);
    assign too_long   = sum_len > (POS_W+1)'(can_dr_pkg::MAX_BYTES);
    assign write_done = cnt_reg >= n_reg;
    assign push_ok    = !out_valid_reg || m_tready;
    assign off_inc    = off_reg + POS_W'(1);
    assign cnt_inc    = cnt_reg + 4'd1;
    assign chunk_end  = (cnt_inc == 4'd8) || (off_inc == len_reg);

    assign base_addr = ADDR_W'(slot_reg) * ADDR_W'(can_dr_pkg::MAX_BYTES);
    assign ram_waddr = base_addr + ADDR_W'(pos_reg) + ADDR_W'(cnt_reg);
    assign ram_raddr = base_addr + ADDR_W'(off_reg);
    assign ram_wdata = data_reg[cnt_reg[2:0]*8 +: 8];
    assign ram_we    = (state_reg == can_dr_pkg::S_WRITE) && !write_done;

    can_dr_ram #(
        .WIDTH (8),
        .DEPTH (can_dr_pkg::DEPTH)
    ) u_bytes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            can_dr_pkg::S_IDLE:
            begin
                if (in_acc && in_keep)
                begin
                    state_next = can_dr_pkg::S_DECIDE;
                end
            end
            can_dr_pkg::S_DECIDE:
            begin
                if (type_reg == can_dr_pkg::TYPE_SINGLE)
                begin
                    state_next = can_dr_pkg::S_PUSH;
                end
                else if (type_reg == can_dr_pkg::TYPE_FIRST)
                begin
                    state_next = (hit || !free_found) ? can_dr_pkg::S_PUSH
                                                      : can_dr_pkg::S_WRITE;
                end
                else
                begin
                    state_next = (!hit || too_long) ? can_dr_pkg::S_PUSH
                                                    : can_dr_pkg::S_WRITE;
                end
            end
            can_dr_pkg::S_WRITE:
            begin
                if (write_done)
                begin
                    if (type_reg != can_dr_pkg::TYPE_FINAL)
                    begin
                        state_next = can_dr_pkg::S_IDLE;
                    end
                    else if (len_reg == '0)
                    begin
                        state_next = can_dr_pkg::S_PUSH;
                    end
                    else
                    begin
                        state_next = can_dr_pkg::S_RADDR;
                    end
                end
            end
            can_dr_pkg::S_RADDR:
            begin
                state_next = can_dr_pkg::S_RDATA;
            end
            can_dr_pkg::S_RDATA:
            begin
                state_next = chunk_end ? can_dr_pkg::S_PUSH : can_dr_pkg::S_RADDR;
            end
            can_dr_pkg::S_PUSH:
            begin
                if (push_ok)
                begin
                    state_next = res_last_reg ? can_dr_pkg::S_IDLE : can_dr_pkg::S_RADDR;
                end
            end
            default:
            begin
                state_next = can_dr_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and slot table
    always_comb
    begin
        valid_next     = valid_reg;
        key_tab_next   = key_tab_reg;
        len_tab_next   = len_tab_reg;
        type_next      = type_reg;
        key_next       = key_reg;
        n_next         = n_reg;
        data_next      = data_reg;
        slot_next      = slot_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        off_next       = off_reg;
        cnt_next       = cnt_reg;
        buf_next       = buf_reg;
        res_kind_next  = res_kind_reg;
        res_err_next   = res_err_reg;
        res_last_next  = res_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        s_tready       = 1'b0;

        case (state_reg)
            can_dr_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (in_acc)
                begin
                    type_next = in_id[26:24];
                    key_next  = in_id[23:0];
                    n_next    = in_n;
                    data_next = in_masked;
                end
            end
            can_dr_pkg::S_DECIDE:
            begin
                cnt_next      = '0;
                res_last_next = 1'b1;
                res_kind_next = can_dr_pkg::KIND_REJECT;
                res_err_next  = can_dr_pkg::ERR_ORDER;
                buf_next      = '0;
                if (type_reg == can_dr_pkg::TYPE_SINGLE)
                begin
                    res_kind_next = can_dr_pkg::KIND_CHUNK;
                    res_err_next  = can_dr_pkg::ERR_NONE;
                    buf_next      = data_reg;
                    cnt_next      = n_reg;
                end
                else if (type_reg == can_dr_pkg::TYPE_FIRST)
                begin
                    if (hit)
                    begin
                        valid_next[hit_idx] = 1'b0;
                    end
                    else if (!free_found)
                    begin
                        res_err_next = can_dr_pkg::ERR_NOSLOT;
                    end
                    else
                    begin
                        valid_next[free_idx]   = 1'b1;
                        key_tab_next[free_idx] = key_reg;
                        len_tab_next[free_idx] = POS_W'(n_reg);
                        slot_next              = free_idx;
                        pos_next               = '0;
                        len_next               = POS_W'(n_reg);
                    end
                end
                else if (hit)
                begin
                    if (too_long)
                    begin
                        valid_next[hit_idx] = 1'b0;
                        res_err_next        = can_dr_pkg::ERR_LONG;
                    end
                    else
                    begin
                        len_tab_next[hit_idx] = POS_W'(sum_len);
                        slot_next             = hit_idx;
                        pos_next              = len_tab_reg[hit_idx];
                        len_next              = POS_W'(sum_len);
                        if (type_reg == can_dr_pkg::TYPE_FINAL)
                        begin
                            valid_next[hit_idx] = 1'b0;
                        end
                    end
                end
            end
            can_dr_pkg::S_WRITE:
            begin
                if (!write_done)
                begin
                    cnt_next = cnt_inc;
                end
                else
                begin
                    cnt_next      = '0;
                    off_next      = '0;
                    buf_next      = '0;
                    res_kind_next = can_dr_pkg::KIND_CHUNK;
                    res_err_next  = can_dr_pkg::ERR_NONE;
                    res_last_next = 1'b1;
                end
            end
            can_dr_pkg::S_RDATA:
            begin
                buf_next[cnt_reg[2:0]*8 +: 8] = ram_rdata;
                cnt_next      = cnt_inc;
                off_next      = off_inc;
                res_last_next = off_inc == len_reg;
            end
            can_dr_pkg::S_PUSH:
            begin
                if (push_ok)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'd0, cnt_reg, buf_reg, key_reg[23:12], key_reg[11:0]};
                    out_user_next  = {res_err_reg, res_kind_reg};
                    out_last_next  = res_last_reg;
                    cnt_next       = '0;
                    buf_next       = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= can_dr_pkg::S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_tab_reg  <= key_tab_next;
        len_tab_reg  <= len_tab_next;
        type_reg     <= type_next;
        key_reg      <= key_next;
        n_reg        <= n_next;
        data_reg     <= data_next;
        slot_reg     <= slot_next;
        pos_reg      <= pos_next;
        len_reg      <= len_next;
        off_reg      <= off_next;
        cnt_reg      <= cnt_next;
        buf_reg      <= buf_next;
        res_kind_reg <= res_kind_next;
        res_err_reg  <= res_err_next;
        res_last_reg <= res_last_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    a_write_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((POS_W+1)'(pos_reg) + (POS_W+1)'(cnt_reg))
                   < (POS_W+1)'(can_dr_pkg::MAX_BYTES))
        else $error("byte write past slot end");

    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata[91:88] == 4'd0)
                                      && (m_tuser[2:1] != can_dr_pkg::ERR_NONE)))
        else $error("rejection notice malformed");

    a_chunk_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> ((m_tdata[91:88] <= 4'd8)
                                       && (m_tuser[2:1] == can_dr_pkg::ERR_NONE)))
        else $error("chunk malformed");

    a_read_in_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == can_dr_pkg::S_RADDR) |-> (off_reg < len_reg))
        else $error("byte read past gathered length");

endmodule

// ===== sim/tb_can_datagram_reassembler.sv =====
module tb_can_datagram_reassembler;

    typedef struct {
        logic        kind;
        logic [11:0] src;
        logic [11:0] dst;
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
        logic [1:0]  err;
    } chunk_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;   // frame_id, byte_count, frame_data, zero pad
    logic [0:0]   s_tuser;   // dest_local
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;   // src_alias, dst_alias, chunk_data, chunk_bytes, zero pad
    logic [2:0]   m_tuser;   // kind, error_kind
    logic         m_tlast;

    can_datagram_reassembler DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // predictor state
    logic        open_valid [can_dr_pkg::SLOTS];
    logic [23:0] open_key   [can_dr_pkg::SLOTS];
    int          open_len   [can_dr_pkg::SLOTS];
    logic [7:0]  open_bytes [can_dr_pkg::SLOTS][can_dr_pkg::MAX_BYTES];

    chunk_t expected_chunks[$];
    int     mismatches;
    int     frames_sent;
    int     chunks_seen;
    int     rejects_seen;
    int     idle_pct;
    int     stall_pct;
    int     quiet_cycles;
    logic [23:0] key_pool[8];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic push_result(input logic kind, input logic [23:0] key, input logic [63:0] d,
                               input logic [3:0] n, input logic last, input logic [1:0] err);
        chunk_t c;
        c.kind   = kind;
        c.src    = key[11:0];
        c.dst    = key[23:12];
        c.data   = d;
        c.nbytes = n;
        c.last   = last;
        c.err    = err;
        expected_chunks.push_back(c);
    endtask

    task automatic reassemble_frame(input logic [28:0] id, input logic [3:0] n,
                                    input logic [63:0] d, input logic loc);
        logic [2:0]  ftype;
        logic [23:0] key;
        int          nn;
        int          s;
        int          f;
        int          len;
        int          off;
        int          k;
        logic [63:0] cd;
        ftype = id[26:24];
        key   = id[23:0];
        if (ftype < can_dr_pkg::TYPE_SINGLE || ftype > can_dr_pkg::TYPE_FINAL || !loc)
            return;
        nn = (n > 8) ? 8 : n;
        if (nn < 8)
            d = d & ((64'd1 << (8 * nn)) - 64'd1);
        if (ftype == can_dr_pkg::TYPE_SINGLE)
        begin
            push_result(can_dr_pkg::KIND_CHUNK, key, d, 4'(nn), 1'b1, can_dr_pkg::ERR_NONE);
            return;
        end
        s = -1;
        for (int i = can_dr_pkg::SLOTS - 1; i >= 0; i--)
            if (open_valid[i] && open_key[i] == key)
                s = i;
        if (ftype == can_dr_pkg::TYPE_FIRST)
        begin
            if (s >= 0)
            begin
                open_valid[s] = 1'b0;
                push_result(can_dr_pkg::KIND_REJECT, key, 64'd0, 4'd0, 1'b1,
                            can_dr_pkg::ERR_ORDER);
                return;
            end
            f = -1;
            for (int i = can_dr_pkg::SLOTS - 1; i >= 0; i--)
                if (!open_valid[i])
                    f = i;
            if (f < 0)
            begin
                push_result(can_dr_pkg::KIND_REJECT, key, 64'd0, 4'd0, 1'b1,
                            can_dr_pkg::ERR_NOSLOT);
                return;
            end
            open_valid[f] = 1'b1;
            open_key[f]   = key;
            for (int i = 0; i < nn; i++)
                open_bytes[f][i] = d[8*i +: 8];
            open_len[f] = nn;
            return;
        end
        if (s < 0)
        begin
            push_result(can_dr_pkg::KIND_REJECT, key, 64'd0, 4'd0, 1'b1,
                        can_dr_pkg::ERR_ORDER);
            return;
        end
        if (open_len[s] + nn > can_dr_pkg::MAX_BYTES)
        begin
            open_valid[s] = 1'b0;
            push_result(can_dr_pkg::KIND_REJECT, key, 64'd0, 4'd0, 1'b1,
                        can_dr_pkg::ERR_LONG);
            return;
        end
        for (int i = 0; i < nn; i++)
            open_bytes[s][open_len[s] + i] = d[8*i +: 8];
        open_len[s] += nn;
        if (ftype == can_dr_pkg::TYPE_MIDDLE)
            return;
        open_valid[s] = 1'b0;
        len = open_len[s];
        off = 0;
        do
        begin
            k  = (len - off > 8) ? 8 : len - off;
            cd = 64'd0;
            for (int i = 0; i < k; i++)
                cd[8*i +: 8] = open_bytes[s][off + i];
            off += k;
            push_result(can_dr_pkg::KIND_CHUNK, key, cd, 4'(k), off >= len,
                        can_dr_pkg::ERR_NONE);
        end
        while (off < len);
    endtask

    task automatic send_frame(input logic [28:0] id, input logic [3:0] n,
                              input logic [63:0] d, input logic loc);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, d, n, id};
        s_tuser  <= loc;
        do
            @(posedge clk);
        while (!s_tready);
        reassemble_frame(id, n, d, loc);
        frames_sent++;
    endtask

    function automatic logic [28:0] make_id(input logic [2:0] ftype, input logic [23:0] key);
        return {2'($urandom_range(3)), ftype, key};
    endfunction

    function automatic logic [63:0] rand_data();
        return {$urandom, $urandom};
    endfunction

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_chunks.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // output side: check each accepted word, random stall, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 5000)
            begin
                $display("timeout: no handshake for %0d cycles", quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                if (m_tuser[0] == can_dr_pkg::KIND_REJECT)
                    rejects_seen++;
                else
                    chunks_seen++;
                if (expected_chunks.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: tdata %h tuser %h tlast %b",
                                 m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    chunk_t e;
                    e = expected_chunks.pop_front();
                    if (m_tuser[0] !== e.kind || m_tdata[11:0] !== e.src
                        || m_tdata[23:12] !== e.dst || m_tdata[87:24] !== e.data
                        || m_tdata[91:88] !== e.nbytes || m_tlast !== e.last
                        || m_tuser[2:1] !== e.err || m_tdata[95:92] !== 4'd0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp kind %0d src %h dst %h data %h n %0d ",
                                      "last %b err %0d / got kind %0d src %h dst %h data %h ",
                                      "n %0d last %b err %0d"},
                                     e.kind, e.src, e.dst, e.data, e.nbytes, e.last, e.err,
                                     m_tuser[0], m_tdata[11:0], m_tdata[23:12],
                                     m_tdata[87:24], m_tdata[91:88], m_tlast, m_tuser[2:1]);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic test_directed();
        logic [23:0] k[6];
        for (int i = 0; i < 6; i++)
            k[i] = {12'($urandom_range(4095)), 12'(i + 1)};
        send_frame({2'b00, 3'd0, 24'h123456}, 4'd8, rand_data(), 1'b1);
        send_frame(29'h1FFFFFFF, 4'd15, rand_data(), 1'b1);
        send_frame(make_id(can_dr_pkg::TYPE_SINGLE, k[0]), 4'd8, rand_data(), 1'b0);
        send_frame({2'b00, can_dr_pkg::TYPE_SINGLE, 24'h000000}, 4'd0, rand_data(), 1'b1);
        send_frame({2'b11, can_dr_pkg::TYPE_SINGLE, 24'hFFFFFF}, 4'd15,
                   64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        // empty datagram
        send_frame(make_id(can_dr_pkg::TYPE_FIRST, k[0]), 4'd0, rand_data(), 1'b1);
        send_frame(make_id(can_dr_pkg::TYPE_FINAL, k[0]), 4'd0, rand_data(), 1'b1);
        // continuation with nothing open
        send_frame(make_id(can_dr_pkg::TYPE_MIDDLE, k[1]), 4'd3, rand_data(), 1'b1);
        send_frame(make_id(can_dr_pkg::TYPE_FINAL, k[1]), 4'd5, rand_data(), 1'b1);
        // fill the table, overflow it, then reopen an open key
        for (int i = 0; i < 4; i++)
            send_frame(make_id(can_dr_pkg::TYPE_FIRST, k[i]), 4'd8, rand_data(), 1'b1);
        send_frame(make_id(can_dr_pkg::TYPE_FIRST, k[4]), 4'd8, rand_data(), 1'b1);
        send_frame(make_id(can_dr_pkg::TYPE_FIRST, k[0]), 4'd2, rand_data(), 1'b1);
        send_frame(make_id(can_dr_pkg::TYPE_FINAL, k[1]), 4'd8, rand_data(), 1'b1);
        send_frame(make_id(can_dr_pkg::TYPE_FINAL, k[2]), 4'd3, rand_data(), 1'b1);
        send_frame(make_id(can_dr_pkg::TYPE_FINAL, k[3]), 4'd9, rand_data(), 1'b1);
        // fill to the maximum, then one byte too many
        send_frame(make_id(can_dr_pkg::TYPE_FIRST, k[5]), 4'd8, rand_data(), 1'b1);
        for (int i = 0; i < 8; i++)
            send_frame(make_id(can_dr_pkg::TYPE_MIDDLE, k[5]), 4'd12, rand_data(), 1'b1);
        send_frame(make_id(can_dr_pkg::TYPE_FINAL, k[5]), 4'd1, rand_data(), 1'b1);
        drain_results();
    endtask

    task automatic test_random(input int sender_idle, input int receiver_stall, input int count);
        int          start;
        int          mode;
        int          mids;
        logic [23:0] key;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        start     = frames_sent;
        while (frames_sent - start < count)
        begin
            mode = $urandom_range(99);
            key  = key_pool[$urandom_range(7)];
            if (mode < 70)
            begin
                mids = ($urandom_range(9) == 0) ? 8 : $urandom_range(3);
                send_frame(make_id(can_dr_pkg::TYPE_FIRST, key), 4'($urandom_range(15)),
                           rand_data(), 1'b1);
                for (int i = 0; i < mids; i++)
                    send_frame(make_id(can_dr_pkg::TYPE_MIDDLE, key), ($urandom_range(1) ? 4'd8
                               : 4'($urandom_range(15))), rand_data(), 1'b1);
                if ($urandom_range(9) != 0)
                    send_frame(make_id(can_dr_pkg::TYPE_FINAL, key), 4'($urandom_range(15)),
                               rand_data(), 1'b1);
            end
            else if (mode < 85)
                send_frame(make_id(3'($urandom_range(can_dr_pkg::TYPE_SINGLE,
                                                     can_dr_pkg::TYPE_FINAL)), key),
                           4'($urandom_range(15)), rand_data(), 1'($urandom_range(1)));
            else
                send_frame(29'($urandom), 4'($urandom_range(15)), rand_data(),
                           1'($urandom_range(1)));
        end
        drain_results();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= 1'b0;
        m_tready     <= 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        mismatches   = 0;
        frames_sent  = 0;
        chunks_seen  = 0;
        rejects_seen = 0;
        quiet_cycles = 0;
        for (int i = 0; i < can_dr_pkg::SLOTS; i++)
            open_valid[i] = 1'b0;
        for (int i = 0; i < 8; i++)
            key_pool[i] = 24'($urandom);
        key_pool[0] = 24'hFFFFFF;
        key_pool[1] = 24'h000000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(0, 0, 32);
        test_random(61, 0, 32);
        test_random(0, 61, 32);
        test_random(20, 20, 32);
        $display("covered %0d frames, %0d chunks and %0d rejections", frames_sent,
                 chunks_seen, rejects_seen);
        $display("idle phases: none, sender 61%%, receiver 61%%, both 20%%; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_chunks.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
